// ----- hdl/apsc_pkg.sv -----
// shared types and constants for the adaptive payload size control block
`timescale 1ns / 1ps
`default_nettype none
package apsc_pkg;

  localparam int FrameW   = 24;
  localparam int AvgW     = 32;
  localparam int PayloadW = 16;
  localparam int FpsW     = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int DivSteps = 32;

  localparam logic [FpsW-1:0]     DefaultFps     = 8'd30;
  localparam logic [PayloadW-1:0] CeilingReset   = 16'd1400;
  localparam logic [PayloadW-1:0] FloorReset     = 16'd64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLE  = 3'd0,
    REG_GOAL    = 3'd1,
    REG_FPS     = 3'd2,
    REG_CEILING = 3'd3,
    REG_FLOOR   = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_CLAMP,
    ST_DECIDE,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ----- hdl/adaptive_payload_size_control_unit.sv -----
// adaptive payload size control: frame size average, payload proposal and hysteresis
//
// one input request on s_axis carries the byte size of one encoded frame; one result
// request on m_axis carries the changed flag and the current payload size.
// configuration goes through cfg_we / cfg_index / cfg_data; the user must see that it is
// written only while idle; the block does not enforce this. a request that is ignored,
// filtered as an outlier or held goes from the evaluate state straight to the result
// register; when a new payload is proposed it passes a 24x8 multiply, a restoring divider
// with one quotient bit per cycle, a clamp, a hysteresis decision, then the result register.
// s_axis_tready is high only while the sequencer is idle, so one request at a time.
// the result stays on m_axis until taken; a stalled receiver holds the block busy.
// reset (synchronous, rst high) clears the average and hold counter, sets the payload
// to 1400 and the registers to enable 0, goal 0, frame rate 0, ceiling 1400, floor 64.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_payload_size_control_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [23:0]                   s_axis_tdata,   // [23:0] frame_size
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [23:0]                        m_axis_tdata,   // [0] updated, [16:1] payload_out
  input  wire logic                          cfg_we,
  input  wire logic [apsc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [apsc_pkg::CfgDataW-1:0] cfg_data
);
  import apsc_pkg::*;

  // configuration registers
  logic                enable;
  logic [15:0]         goal;
  logic [FpsW-1:0]     frame_rate;
  logic [PayloadW-1:0] ceiling;
  logic [PayloadW-1:0] floor_val;

  // state
  logic [AvgW-1:0]     smoothed;
  logic [7:0]          hold_count;
  logic [PayloadW-1:0] payload_now;

  // sequencer and datapath
  state_t              state, state_next;
  logic [FrameW-1:0]   frame;
  logic                upd;
  logic [31:0]         quo;
  logic [15:0]         rem;
  logic [4:0]          cnt;
  logic [PayloadW-1:0] target;

  logic [FpsW-1:0]     fps;
  logic [FrameW-1:0]   avg;
  logic [FrameW+1:0]   avg_x3;
  logic                pass;
  logic [AvgW-1:0]     smoothed_upd;
  logic [AvgW-1:0]     smoothed_new;
  logic [16:0]         rem_shift;
  logic                q_bit;
  logic [PayloadW-1:0] cap;
  logic [31:0]         tgt_lo;
  logic [PayloadW-1:0] delta;
  logic [20:0]         delta_x20;
  logic [20:0]         cur_x3;
  logic                bound;
  logic                do_change;

  assign fps    = (frame_rate == '0) ? DefaultFps : frame_rate;
  assign avg    = smoothed[AvgW-1:8];
  assign avg_x3 = {2'b00, avg} + {1'b0, avg, 1'b0};
  assign pass   = enable && (frame != '0) && (goal != '0) &&
                  !((avg != '0) && ({2'b00, frame} > avg_x3));

  assign smoothed_upd = smoothed - {2'b00, smoothed[AvgW-1:2]} + {2'b00, frame, 6'd0};
  assign smoothed_new = (smoothed == '0) ? {frame, 8'd0} : smoothed_upd;

  // one restoring divider step
  assign rem_shift = {rem, quo[31]};
  assign q_bit     = (rem_shift >= {1'b0, goal});

  // clamp
  assign cap    = (ceiling < floor_val) ? floor_val : ceiling;
  assign tgt_lo = (quo < {16'd0, floor_val}) ? {16'd0, floor_val} : quo;

  // hysteresis: change a differing target at floor or cap, or when 20*delta > 3*cur
  assign delta     = (target > payload_now) ? (target - payload_now) : (payload_now - target);
  assign delta_x20 = {1'b0, delta, 4'd0} + {3'b000, delta, 2'b00};
  assign cur_x3    = {5'd0, payload_now} + {4'd0, payload_now, 1'b0};
  assign bound     = (target == floor_val) || (target == cap);
  assign do_change = (target != payload_now) && (bound || (delta_x20 > cur_x3));

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      goal       <= '0;
      frame_rate <= '0;
      ceiling    <= CeilingReset;
      floor_val  <= FloorReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:  enable     <= cfg_data[0];
        REG_GOAL:    goal       <= cfg_data;
        REG_FPS:     frame_rate <= cfg_data[FpsW-1:0];
        REG_CEILING: ceiling    <= cfg_data;
        REG_FLOOR:   floor_val  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (pass && (hold_count == '0)) state_next = ST_MUL;
        else state_next = ST_OUT;
      end
      ST_MUL: state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == 5'(DivSteps - 1)) state_next = ST_CLAMP;
      end
      ST_CLAMP:  state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_OUT;
      ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed    <= '0;
      hold_count  <= '0;
      payload_now <= CeilingReset;
      upd         <= 1'b0;
    end else begin
      case (state)
        ST_EVAL: begin
          upd <= 1'b0;
          if (pass) begin
            smoothed <= smoothed_new;
            if (hold_count != '0) hold_count <= hold_count - 8'd1;
          end
        end
        ST_DECIDE: begin
          if (do_change) begin
            payload_now <= target;
            hold_count  <= {1'b0, fps[FpsW-1:1]};
            upd         <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) frame <= s_axis_tdata;
      end
      ST_MUL: begin
        quo <= {8'd0, avg} * {24'd0, fps};
        rem <= '0;
        cnt <= '0;
      end
      ST_DIV: begin
        rem <= q_bit ? 16'(rem_shift - {1'b0, goal}) : rem_shift[15:0];
        quo <= {quo[30:0], q_bit};
        cnt <= cnt + 5'd1;
      end
      ST_CLAMP: begin
        target <= (tgt_lo > {16'd0, cap}) ? cap : tgt_lo[PayloadW-1:0];
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {7'd0, payload_now, upd};

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// self-checking testbench for the adaptive payload size control unit
`timescale 1ns / 1ps
module testbench;
  import apsc_pkg::*;

  localparam int RandomItems   = 1900;
  localparam int WatchdogLimit = 4000;
  localparam int SettleCycles  = 4;
  localparam int EndCycles     = 60;
  localparam int HystNum       = 3;
  localparam int HystDen       = 20;
  localparam logic [23:0] FrameMax = 24'hFFFFFF;

  typedef struct packed {
    logic                updated;
    logic [PayloadW-1:0] payload;
  } payload_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;
  logic                cfg_we = 1'b0;
  cfg_reg_t            cfg_index = REG_ENABLE;
  logic [CfgDataW-1:0] cfg_data = '0;

  // predictor copy of the block's registers and state
  logic                mdl_enable   = 1'b0;
  logic [15:0]         mdl_goal     = '0;
  logic [FpsW-1:0]     mdl_fps      = '0;
  logic [15:0]         mdl_ceiling  = CeilingReset;
  logic [15:0]         mdl_floor    = FloorReset;
  logic [AvgW-1:0]     mdl_smoothed = '0;
  logic [FpsW-1:0]     mdl_hold     = '0;
  logic [PayloadW-1:0] mdl_payload  = CeilingReset;

  payload_result_t frame_results[$];

  bit frame_taken;
  bit no_idle = 1'b0;
  int fail_count    = 0;
  int frames_sent   = 0;
  int frames_taken  = 0;
  int outliers_seen = 0;
  int results_seen  = 0;
  int changes_seen  = 0;
  int phases_run    = 0;
  int idle_cycles   = 0;
  int stall_left    = 0;

  adaptive_payload_size_control_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [23:0] frame_size
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [0] updated, [16:1] payload_out
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // advances the average, hold counter and payload for one frame
  function automatic payload_result_t step_payload(input logic [23:0] size);
    logic [23:0]     avg;
    logic [31:0]     scaled, target, cap, cur, delta;
    logic [FpsW-1:0] fps;
    logic [63:0]     prod;
    payload_result_t res;
    res.updated = 1'b0;
    frame_taken = 1'b0;
    avg = mdl_smoothed[31:8];
    if (mdl_enable && size != 0 && mdl_goal != 0) begin
      if (avg != 0 && {8'd0, size} > 32'(avg) * 32'd3) begin
        outliers_seen++;
      end else begin
        frame_taken = 1'b1;
        scaled = {size, 8'd0};
        if (mdl_smoothed == 0) mdl_smoothed = scaled;
        else mdl_smoothed = mdl_smoothed - (mdl_smoothed >> 2) + (scaled >> 2);
        if (mdl_hold != 0) begin
          mdl_hold = mdl_hold - 1'b1;
        end else begin
          fps = (mdl_fps != 0) ? mdl_fps : DefaultFps;
          cap = (mdl_ceiling < mdl_floor) ? 32'(mdl_floor) : 32'(mdl_ceiling);
          prod = 64'(mdl_smoothed[31:8]) * 64'(fps);
          target = 32'(prod / 64'(mdl_goal));
          if (target < 32'(mdl_floor)) target = 32'(mdl_floor);
          if (target > cap) target = cap;
          cur = 32'(mdl_payload);
          if (target != cur) begin
            delta = (target > cur) ? target - cur : cur - target;
            if (target == 32'(mdl_floor) || target == cap ||
                delta > (cur * HystNum) / HystDen) begin
              mdl_payload = target[15:0];
              mdl_hold = fps >> 1;
              res.updated = 1'b1;
            end
          end
        end
      end
    end
    res.payload = mdl_payload;
    return res;
  endfunction

  task automatic send_frame(input logic [23:0] size);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= size;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    frame_results.push_back(step_payload(size));
    frames_sent++;
    if (frame_taken) frames_taken++;
  endtask

  // stop sending and wait for every outstanding result
  task automatic finish_requests();
    s_axis_tvalid <= 1'b0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [CfgDataW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic apply_config(input bit en, input logic [15:0] goal, input logic [7:0] fps,
                              input logic [15:0] ceiling, input logic [15:0] flo);
    finish_requests();
    write_cfg(REG_ENABLE, {15'd0, en});
    write_cfg(REG_GOAL, goal);
    write_cfg(REG_FPS, {8'd0, fps});
    write_cfg(REG_CEILING, ceiling);
    write_cfg(REG_FLOOR, flo);
    cfg_we <= 1'b0;
    mdl_enable = en;
    mdl_goal = goal;
    mdl_fps = fps;
    mdl_ceiling = ceiling;
    mdl_floor = flo;
    phases_run++;
  endtask

  // result side: random back-pressure and in-order comparison
  always @(posedge clk) begin
    payload_result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (frame_results.size() == 0) begin
          $error("result with no request outstanding: tdata %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = frame_results.pop_front();
          if (m_axis_tdata[0] !== want.updated) begin
            $error("updated: expected %0b, got %0b", want.updated, m_axis_tdata[0]);
            fail_count++;
          end
          if (m_axis_tdata[16:1] !== want.payload) begin
            $error("payload_out: expected %0d, got %0d", want.payload, m_axis_tdata[16:1]);
            fail_count++;
          end
          if (want.updated) changes_seen++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (no_idle || $urandom_range(0, 99) < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        m_axis_tready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // registers still at reset: enable is low so the frame is ignored
  task automatic test_disabled_block();
    send_frame(24'd1000);
    finish_requests();
  endtask

  task automatic test_ignored_frames();
    apply_config(1'b1, 16'd0, 8'd4, 16'hFFFF, 16'd1);
    send_frame(24'h123456);
    apply_config(1'b1, 16'hFFFF, 8'd4, 16'hFFFF, 16'd1);
    send_frame(24'd0);
    finish_requests();
  endtask

  // first sample loads the average, then hold, then an equal proposal
  task automatic test_first_sample();
    repeat (4) send_frame(FrameMax);
    finish_requests();
  endtask

  task automatic test_outlier_frames();
    repeat (4) send_frame(24'd1);
    send_frame(FrameMax);
    send_frame(24'd1);
    finish_requests();
  endtask

  // zero floor, ceiling under floor, floor at its maximum
  task automatic test_payload_bounds();
    apply_config(1'b1, 16'hFFFF, 8'd2, 16'd0, 16'd0);
    repeat (3) send_frame(24'h000100);
    apply_config(1'b1, 16'hFFFF, 8'd2, 16'd100, 16'd200);
    repeat (3) send_frame(24'h000100);
    apply_config(1'b1, 16'hFFFF, 8'd2, 16'd0, 16'hFFFF);
    repeat (3) send_frame(24'h000100);
    finish_requests();
  endtask

  task automatic run_random_phase();
    int unsigned center, spread, avg, frame, lo, hi, desired, fps_eff, r, top;
    logic [63:0] goal_calc;
    logic [15:0] goal, flo, ceiling;
    logic [7:0]  fps;
    bit          en;
    int          count;
    r = $urandom_range(4, 24);
    center = $urandom_range(1, (32'd1 << r) - 1);
    r = $urandom_range(0, 9);
    fps = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(1, 12));
    fps_eff = (fps != 0) ? fps : DefaultFps;
    r = $urandom_range(0, 9);
    flo = (r == 0) ? 16'd0 : (r == 1) ? 16'($urandom) : 16'($urandom_range(1, 600));
    r = $urandom_range(0, 9);
    if (r == 0) ceiling = 16'($urandom_range(0, flo));
    else if (r == 1) ceiling = 16'hFFFF;
    else begin
      top = 32'(flo) + $urandom_range(100, 4000);
      ceiling = 16'((top > 65535) ? 65535 : top);
    end
    lo = flo / 2 + 1;
    hi = (ceiling > flo ? ceiling : flo) * 5 / 4 + 1;
    desired = $urandom_range(lo, hi);
    goal_calc = 64'(center) * 64'(fps_eff) / 64'(desired);
    goal = (goal_calc == 0) ? 16'd1 : (goal_calc > 65535) ? 16'hFFFF : goal_calc[15:0];
    r = $urandom_range(0, 99);
    if (r < 5) goal = 16'd0;
    else if (r < 15) goal = 16'($urandom);
    en = ($urandom_range(0, 99) < 92);
    apply_config(en, goal, fps, ceiling, flo);
    no_idle = ($urandom_range(0, 99) < 15);
    count = $urandom_range(40, 150);
    repeat (count) begin
      avg = mdl_smoothed[31:8];
      r = $urandom_range(0, 99);
      if (r < 4) begin
        frame = $urandom & 32'hFFFFFF;
      end else if (r < 7 && avg != 0 && avg * 3 < 32'hFFFFFF) begin
        frame = avg * 3 + $urandom_range(1, 32'hFFFFFF - avg * 3);
      end else if (r < 9) begin
        frame = 0;
      end else begin
        spread = center / 8;
        frame = center - spread + $urandom_range(0, 2 * spread);
        // ramp toward the center without tripping the outlier filter
        if (avg != 0 && frame > avg * 3) frame = avg * 3;
        if (frame == 0) frame = 1;
        if (frame > 32'hFFFFFF) frame = 32'hFFFFFF;
      end
      send_frame(frame[23:0]);
      if ($urandom_range(0, 99) < 3) finish_requests();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    int start_sent;
    start_sent = frames_sent;
    while (frames_sent - start_sent < RandomItems) run_random_phase();
    finish_requests();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_disabled_block();
    test_ignored_frames();
    test_first_sample();
    test_outlier_frames();
    test_payload_bounds();
    test_random_traffic();
    repeat (EndCycles) @(posedge clk);
    $display("sent %0d frames over %0d register settings: %0d averaged, %0d outliers",
             frames_sent, phases_run, frames_taken, outliers_seen);
    $display("checked %0d results, %0d of them payload changes", results_seen, changes_seen);
    if (fail_count == 0 && frame_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
